>>> hdl/wcs_pkg.sv
// shared types and constants for the wide character string search
`timescale 1ns / 1ps
`default_nettype none
package wcs_pkg;

   localparam int PATTERN_MAX   = 64;
   localparam int SYMBOL_BITS   = 16;
   localparam int POSITION_BITS = 31;
   localparam int LENGTH_BITS   = 7;
   localparam int INDEX_BITS    = $clog2(PATTERN_MAX);

   typedef enum logic [0:0] {
      ACTION_LOAD = 1'b0,
      ACTION_TEXT = 1'b1
   } action_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic clear;
   } cell_ctrl_type;

   typedef struct packed {
      logic                     found;
      logic [POSITION_BITS-1:0] match_start;
   } result_type;

endpackage
`default_nettype wire

>>> hdl/wcs_cell.sv
// one pattern cell: stored character, compare and match bit
`timescale 1ns / 1ps
`default_nettype none
module wcs_cell (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire wcs_pkg::cell_ctrl_type         ctrl,
   input  wire logic [wcs_pkg::SYMBOL_BITS-1:0] symbol,
   input  wire logic                           carry_in,
   output logic                                hit,
   output logic                                match_out
);

   logic [wcs_pkg::SYMBOL_BITS-1:0] pattern_ff;
   logic                            match_ff;
   logic                            match_in;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         pattern_ff <= symbol;
      end
   end

   assign hit = carry_in && (pattern_ff == symbol);

   always_comb begin
      match_in = match_ff;
      if (ctrl.shift) begin
         match_in = ctrl.clear ? 1'b0 : hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign match_out = match_ff;

endmodule
`default_nettype wire

>>> hdl/wcs_rsp_queue.sv
// two-entry result buffer between the search chain and the result channel
`timescale 1ns / 1ps
`default_nettype none
module wcs_rsp_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire wcs_pkg::result_type  push_data,
   output logic                      full,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output wcs_pkg::result_type       rsp_data
);

   wcs_pkg::result_type entry_ff [2];
   logic                head_ff, head_in;
   logic                tail_ff, tail_in;
   logic [1:0]          count_ff, count_in;
   logic                pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_data  = entry_ff[head_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

   always_comb begin
      head_in  = pop ? ~head_ff : head_ff;
      tail_in  = push ? ~tail_ff : tail_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         tail_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("result pushed into a full buffer");

   a_count_steady: assert property (@(posedge clock) disable iff (reset)
      (push && pop) |=> (count_ff == $past(count_ff)))
      else $error("buffer count moved on simultaneous push and pop");

endmodule
`default_nettype wire

>>> hdl/wide_char_exact_string_search.sv
// top level: first exact match of a 16-bit character pattern in a text stream
// One item is accepted per clock unless stalled. Load items write a pattern
// character into its cell; text items compare it against all cells at once and
// shift the match bits one cell along the chain, so the result for an item is
// known in the cycle it is accepted and lands in a two-entry result buffer in the next cycle.
// req_stall rises only while both buffer entries hold untaken results. There is
// no clearing pass after reset; pattern cells read as undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module wide_char_exact_string_search (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_action,
   input  wire logic [wcs_pkg::SYMBOL_BITS-1:0]  req_symbol,
   input  wire logic [wcs_pkg::INDEX_BITS-1:0]   req_pattern_index,
   input  wire logic                             req_last,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_found,
   output logic [wcs_pkg::POSITION_BITS-1:0]     rsp_match_start,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [wcs_pkg::LENGTH_BITS-1:0]  csr_pattern_length
);

   localparam int PM = wcs_pkg::PATTERN_MAX;
   localparam int PB = wcs_pkg::POSITION_BITS;
   localparam int IB = wcs_pkg::INDEX_BITS;
   localparam int LB = wcs_pkg::LENGTH_BITS;
   localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};

   logic [LB-1:0]       length_ff;
   logic [PB-1:0]       position_ff, position_in;
   logic                reported_ff, reported_in;
   logic                accept, text_item, full;
   logic [PM-1:0]       hit_vec, match_vec;
   logic [IB-1:0]       len_idx;
   logic [LB-1:0]       len_m1;
   logic                hit_sel, push;
   wcs_pkg::result_type push_data, rsp_data;
   wcs_pkg::cell_ctrl_type cell_ctrl [PM];

   assign csr_ready = 1'b1;
   assign req_stall = full;
   assign accept    = req_valid && !req_stall;
   assign text_item = accept && (req_action == wcs_pkg::ACTION_TEXT);

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LB'(1);
      end else if (csr_valid && csr_ready) begin
         length_ff <= csr_pattern_length;
      end
   end

   // pattern cell chain
   for (genvar i = 0; i < PM; i++) begin : g_cell
      logic carry;
      if (i == 0) begin : g_head
         assign carry = 1'b1;
      end else begin : g_link
         assign carry = match_vec[i-1];
      end
      always_comb begin
         cell_ctrl[i].load  = accept && (req_action == wcs_pkg::ACTION_LOAD)
                              && (req_pattern_index == IB'(i));
         cell_ctrl[i].shift = text_item;
         cell_ctrl[i].clear = req_last;
      end
      wcs_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl[i]),
         .symbol    (req_symbol),
         .carry_in  (carry),
         .hit       (hit_vec[i]),
         .match_out (match_vec[i])
      );
   end

   // effective length minus one, clamped to the chain
   assign len_m1 = length_ff - LB'(1);
   always_comb begin
      priority if (length_ff == LB'(0)) begin
         len_idx = '0;
      end else if (length_ff > LB'(PM)) begin
         len_idx = IB'(PM - 1);
      end else begin
         len_idx = len_m1[IB-1:0];
      end
   end

   assign hit_sel = hit_vec[len_idx];

   always_comb begin
      push_data.found       = hit_sel;
      push_data.match_start = '0;
      if (hit_sel && (position_ff >= PB'(len_idx))) begin
         push_data.match_start = position_ff - PB'(len_idx);
      end
      push = text_item && !reported_ff && (hit_sel || req_last);
   end

   always_comb begin
      position_in = position_ff;
      reported_in = reported_ff;
      if (text_item) begin
         if (req_last) begin
            position_in = '0;
            reported_in = 1'b0;
         end else begin
            if (position_ff != POS_MAX) begin
               position_in = position_ff + PB'(1);
            end
            if (hit_sel) begin
               reported_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         reported_ff <= 1'b0;
      end else begin
         position_ff <= position_in;
         reported_ff <= reported_in;
      end
   end

   wcs_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_found       = rsp_data.found;
   assign rsp_match_start = rsp_data.match_start;

   a_report_once: assert property (@(posedge clock) disable iff (reset)
      (text_item && reported_ff) |-> !push)
      else $error("second result in one search");

   a_mark_reported: assert property (@(posedge clock) disable iff (reset)
      (push && push_data.found && !req_last) |=> reported_ff)
      else $error("match not recorded as reported");

   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      (text_item && req_last) |=> (position_ff == '0 && match_vec == '0 && !reported_ff))
      else $error("search state not cleared after last item");

   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_action == wcs_pkg::ACTION_LOAD)) |-> !push)
      else $error("load item produced a result");

endmodule
`default_nettype wire

>>> tb/sv/search_checker.sv
// checker for the string search: predicts first-match results from observed items and compares
`timescale 1ns / 1ps
module search_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   input  wire logic                             req_stall,
   input  wire logic                             req_action,
   input  wire logic [wcs_pkg::SYMBOL_BITS-1:0]  req_symbol,
   input  wire logic [wcs_pkg::INDEX_BITS-1:0]   req_pattern_index,
   input  wire logic                             req_last,
   input  wire logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   input  wire logic                             rsp_found,
   input  wire logic [wcs_pkg::POSITION_BITS-1:0] rsp_match_start,
   input  wire logic                             csr_valid,
   input  wire logic                             csr_ready,
   input  wire logic [wcs_pkg::LENGTH_BITS-1:0]  csr_pattern_length,
   output int                                    mismatch_count,
   output int                                    pending_count,
   output int                                    found_count,
   output int                                    miss_count
);

   logic [wcs_pkg::SYMBOL_BITS-1:0]   cell_copy [wcs_pkg::PATTERN_MAX];
   logic [wcs_pkg::PATTERN_MAX-1:0]   prefix_hits = '0;
   logic [wcs_pkg::POSITION_BITS-1:0] next_index = '0;
   logic                              hit_reported = 1'b0;
   logic [wcs_pkg::LENGTH_BITS-1:0]   length_copy = 7'd1;
   wcs_pkg::result_type               awaited_results [$];
   int                                failures = 0;
   int                                hits = 0;
   int                                misses = 0;

   task automatic report_mismatch(input string what);
      failures++;
      $display("mismatch at %0t ns: %s", $time, what);
   endtask

   // one text character: compare against all cells, shift the prefix bits, decide the result
   task automatic advance_search(input logic [wcs_pkg::SYMBOL_BITS-1:0] symbol,
                                 input logic last);
      logic [wcs_pkg::PATTERN_MAX-1:0]   equal_bits;
      logic [wcs_pkg::POSITION_BITS-1:0] char_index;
      wcs_pkg::result_type               outcome;
      int                                span;
      int                                i;
      equal_bits = '0;
      for (i = 0; i < wcs_pkg::PATTERN_MAX; i++) begin
         equal_bits[i] = (cell_copy[i] == symbol);
      end
      if (length_copy == 0) begin
         span = 1;
      end else if (length_copy > wcs_pkg::PATTERN_MAX) begin
         span = wcs_pkg::PATTERN_MAX;
      end else begin
         span = int'(length_copy);
      end
      char_index = next_index;
      if (next_index != '1) begin
         next_index = next_index + 1'b1;
      end
      prefix_hits = {prefix_hits[wcs_pkg::PATTERN_MAX-2:0], 1'b1} & equal_bits;
      if (!hit_reported && prefix_hits[span-1]) begin
         outcome.found = 1'b1;
         outcome.match_start = (char_index >= span - 1) ?
                               wcs_pkg::POSITION_BITS'(char_index - (span - 1)) : '0;
         hit_reported = 1'b1;
         hits++;
         awaited_results.push_back(outcome);
      end else if (last && !hit_reported) begin
         outcome = '0;
         misses++;
         awaited_results.push_back(outcome);
      end
      if (last) begin
         prefix_hits = '0;
         next_index = '0;
         hit_reported = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      wcs_pkg::result_type oldest;
      if (reset) begin
         prefix_hits = '0;
         next_index = '0;
         hit_reported = 1'b0;
         length_copy = 7'd1;
         awaited_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            length_copy = csr_pattern_length;
         end
         if (req_valid && !req_stall) begin
            if (req_action == wcs_pkg::ACTION_TEXT) begin
               advance_search(req_symbol, req_last);
            end else begin
               cell_copy[req_pattern_index] = req_symbol;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("result item with none expected");
            end else begin
               oldest = awaited_results.pop_front();
               if (rsp_found !== oldest.found) begin
                  report_mismatch($sformatf("found %b, expected %b", rsp_found, oldest.found));
               end
               if (rsp_match_start !== oldest.match_start) begin
                  report_mismatch($sformatf("match_start %0d, expected %0d",
                                            rsp_match_start, oldest.match_start));
               end
            end
         end
      end
      mismatch_count <= failures;
      pending_count <= awaited_results.size();
      found_count <= hits;
      miss_count <= misses;
   end

endmodule

>>> tb/sv/testbench.sv
// testbench top: drives pattern loads, text and length writes into the string search
`timescale 1ns / 1ps
module testbench;

   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_ITEMS = 1000;
   localparam int DRAIN_CYCLES = 8;
   localparam int SETTLE_CYCLES = 4;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic                              req_action = 1'b0;
   logic [wcs_pkg::SYMBOL_BITS-1:0]   req_symbol = '0;
   logic [wcs_pkg::INDEX_BITS-1:0]    req_pattern_index = '0;
   logic                              req_last = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic                              rsp_found;
   logic [wcs_pkg::POSITION_BITS-1:0] rsp_match_start;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [wcs_pkg::LENGTH_BITS-1:0]   csr_pattern_length = 7'd1;

   int mismatch_count;
   int pending_count;
   int found_count;
   int miss_count;

   logic [wcs_pkg::SYMBOL_BITS-1:0] cell_mirror [wcs_pkg::PATTERN_MAX];
   logic [wcs_pkg::SYMBOL_BITS-1:0] alphabet [4];
   bit                              steady = 1'b0;
   int                              idle_cycles = 0;
   int                              text_items = 0;
   int                              load_items = 0;
   int                              length_writes = 0;

   always #2 clock = ~clock;

   wide_char_exact_string_search DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_symbol         (req_symbol),
      .req_pattern_index  (req_pattern_index),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_found          (rsp_found),
      .rsp_match_start    (rsp_match_start),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_pattern_length (csr_pattern_length)
   );

   search_checker RESULT_CHECK (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_symbol         (req_symbol),
      .req_pattern_index  (req_pattern_index),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_found          (rsp_found),
      .rsp_match_start    (rsp_match_start),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_pattern_length (csr_pattern_length),
      .mismatch_count     (mismatch_count),
      .pending_count      (pending_count),
      .found_count        (found_count),
      .miss_count         (miss_count)
   );

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int draw_wait();
      if (steady) begin
         return 0;
      end
      return $urandom_range(0, 7);
   endfunction

   initial begin : receiver
      int hold;
      while (reset) @(posedge clock);
      forever begin
         hold = draw_wait();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   task automatic send_item(input wcs_pkg::action_type act,
                            input logic [wcs_pkg::SYMBOL_BITS-1:0] symbol,
                            input logic [wcs_pkg::INDEX_BITS-1:0] index,
                            input logic last);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_symbol <= symbol;
      req_pattern_index <= index;
      req_last <= last;
      do @(posedge clock); while (req_stall);
      if (act == wcs_pkg::ACTION_TEXT) begin
         text_items++;
      end else begin
         load_items++;
      end
   endtask

   task automatic load_cell(input int index, input logic [wcs_pkg::SYMBOL_BITS-1:0] symbol,
                            input logic last);
      cell_mirror[index] = symbol;
      send_item(wcs_pkg::ACTION_LOAD, symbol, wcs_pkg::INDEX_BITS'(index), last);
   endtask

   task automatic send_text(input logic [wcs_pkg::SYMBOL_BITS-1:0] symbol, input logic last);
      send_item(wcs_pkg::ACTION_TEXT, symbol,
                wcs_pkg::INDEX_BITS'($urandom_range(0, wcs_pkg::PATTERN_MAX - 1)), last);
   endtask

   // hold the sender until every expected result item is back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(input logic [wcs_pkg::LENGTH_BITS-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_pattern_length <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      length_writes++;
   endtask

   initial begin : stimulus
      int                              i;
      int                              phase;
      int                              base;
      int                              pick;
      int                              span;
      int                              letters;
      int                              searches;
      int                              s;
      int                              t;
      int                              text_len;
      int                              offset;
      bit                              planted;
      logic [wcs_pkg::LENGTH_BITS-1:0] value;
      logic [wcs_pkg::SYMBOL_BITS-1:0] symbol;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // every cell loaded before any text so no compare sees an unloaded cell
      for (i = 0; i < wcs_pkg::PATTERN_MAX; i++) begin
         load_cell(i, wcs_pkg::SYMBOL_BITS'(16'hFFFF - i * 16'h0401), i[0]);
      end

      // single character at the reset length, then text after the match
      send_text(16'h0000, 1'b0);
      send_text(cell_mirror[0], 1'b0);
      send_text(cell_mirror[0], 1'b0);
      send_text(cell_mirror[5], 1'b1);
      // text shorter than the pattern, then a match on the last item
      write_length(7'd3);
      send_text(cell_mirror[0], 1'b0);
      send_text(cell_mirror[1], 1'b1);
      send_text(cell_mirror[0], 1'b0);
      send_text(cell_mirror[1], 1'b0);
      send_text(cell_mirror[2], 1'b1);
      // zero length acts as one, oversized length as the full pattern
      write_length(7'd0);
      send_text(cell_mirror[0], 1'b1);
      write_length(7'd127);
      send_text(cell_mirror[0], 1'b0);
      send_text(cell_mirror[1], 1'b0);
      send_text(cell_mirror[2], 1'b1);
      // length lowered partway through a search
      write_length(7'd4);
      send_text(cell_mirror[0], 1'b0);
      send_text(cell_mirror[1], 1'b0);
      write_length(7'd3);
      send_text(cell_mirror[2], 1'b1);
      // cell rewritten partway through a search, load with last set
      write_length(7'd2);
      send_text(cell_mirror[0], 1'b0);
      load_cell(1, 16'h5A5A, 1'b1);
      send_text(16'h5A5A, 1'b1);

      base = text_items + load_items;
      phase = 0;
      while (text_items + load_items < base + RANDOM_ITEMS) begin
         pick = (phase == 0) ? 0 : $urandom_range(0, 15);
         case (pick)
            0: begin
               span = wcs_pkg::PATTERN_MAX;
               value = wcs_pkg::LENGTH_BITS'(64 + $urandom_range(0, 63));
            end
            1: begin
               span = 1;
               value = wcs_pkg::LENGTH_BITS'($urandom_range(0, 1));
            end
            2: begin
               span = $urandom_range(9, wcs_pkg::PATTERN_MAX);
               value = wcs_pkg::LENGTH_BITS'(span);
            end
            default: begin
               span = $urandom_range(1, 8);
               value = wcs_pkg::LENGTH_BITS'(span);
            end
         endcase
         write_length(value);
         steady = ($urandom_range(0, 3) == 0);

         letters = $urandom_range(1, 3);
         for (i = 0; i < letters; i++) begin
            alphabet[i] = wcs_pkg::SYMBOL_BITS'($urandom);
         end
         for (i = 0; i < span; i++) begin
            load_cell(i, alphabet[$urandom_range(0, letters - 1)], 1'($urandom_range(0, 1)));
         end
         if (span < wcs_pkg::PATTERN_MAX && $urandom_range(0, 1) == 1) begin
            load_cell($urandom_range(span, wcs_pkg::PATTERN_MAX - 1),
                      wcs_pkg::SYMBOL_BITS'($urandom), 1'($urandom_range(0, 1)));
         end

         searches = (span > 16) ? 1 : $urandom_range(1, 3);
         for (s = 0; s < searches; s++) begin
            if ($urandom_range(0, 7) == 0) begin
               text_len = $urandom_range(1, span);
            end else begin
               text_len = span + $urandom_range(0, 8);
            end
            planted = (text_len >= span) && ($urandom_range(0, 3) != 0);
            offset = planted ? $urandom_range(0, text_len - span) : 0;
            for (t = 0; t < text_len; t++) begin
               if ($urandom_range(0, 49) == 0) begin
                  load_cell($urandom_range(0, wcs_pkg::PATTERN_MAX - 1),
                            alphabet[$urandom_range(0, letters - 1)],
                            1'($urandom_range(0, 1)));
               end
               if (planted && t >= offset && t < offset + span) begin
                  symbol = cell_mirror[t - offset];
               end else if ($urandom_range(0, 9) == 0) begin
                  symbol = wcs_pkg::SYMBOL_BITS'($urandom);
               end else begin
                  symbol = alphabet[$urandom_range(0, letters - 1)];
               end
               // now and then the search runs on into the next one without a last
               send_text(symbol, (t == text_len - 1) && ($urandom_range(0, 9) != 0));
            end
         end
         phase++;
      end

      steady = 1'b0;
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d text items, %0d pattern loads and %0d length writes",
               text_items, load_items, length_writes);
      $display("searches closed with %0d matches and %0d not-found results",
               found_count, miss_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
